// File: hdl/lpmr_pkg.sv
package lpmr_pkg;

    localparam int RING_BYTES   = 65536;
    localparam int HEADER_BYTES = 8;
    localparam int POS_W        = $clog2(RING_BYTES);
    localparam int SIZE_W       = 17;
    localparam int LEN_W        = 16;
    localparam int CNT_W        = 13;
    localparam int HDR_CNT_W    = $clog2(HEADER_BYTES);
    localparam int SIZE_MIN     = 16;
    localparam int SIZE_MAX     = (RING_BYTES < 65536) ? RING_BYTES : 65536;

    typedef enum logic [1:0] {
        ACT_PUSH_START = 2'd0,
        ACT_PUSH_BYTE  = 2'd1,
        ACT_POP_BYTE   = 2'd2,
        ACT_UNUSED     = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_BAD   = 2'd3
    } status_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    latch_in;
        logic    set_status;
        status_t status;
        logic    wr_hdr;
        logic    wr_body;
        logic    start_rd;
        logic    adv_cursor;
        logic    cap_lo;
        logic    cap_hi;
        logic    body_step;
        logic    cap_body;
        logic    pop_end;
        logic    load_out;
    } lpmr_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        action_t act;
        logic    push_open;
        logic    full;
        logic    empty;
        logic    pop_open;
        logic    pop_left_zero;
        logic    hdr_done;
        logic    out_free;
    } lpmr_stat_t;

    function automatic logic [POS_W-1:0] wrap_inc(input logic [POS_W-1:0] pos,
                                                 input logic [SIZE_W-1:0] size);
        logic [SIZE_W-1:0] sum;
        sum = {1'b0, pos} + SIZE_W'(1);
        wrap_inc = (sum == size) ? '0 : sum[POS_W-1:0];
    endfunction

    function automatic logic [POS_W-1:0] wrap_add_hdr(input logic [POS_W-1:0] pos,
                                                     input logic [SIZE_W-1:0] size);
        logic [SIZE_W-1:0] sum;
        logic [SIZE_W-1:0] dif;
        sum = {1'b0, pos} + SIZE_W'(HEADER_BYTES);
        dif = sum - size;
        wrap_add_hdr = (sum >= size) ? dif[POS_W-1:0] : sum[POS_W-1:0];
    endfunction

    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
        if (v < SIZE_W'(SIZE_MIN)) begin
            clamp_size = SIZE_W'(SIZE_MIN);
        end else if (v > SIZE_W'(SIZE_MAX)) begin
            clamp_size = SIZE_W'(SIZE_MAX);
        end else begin
            clamp_size = v;
        end
    endfunction

endpackage

// File: hdl/length_prefixed_message_ring.sv
// Byte ring of variable-length messages, each stored as an 8-byte little-endian
// length header and its body, both wrapping at the configured ring size. One
// beat in gives one beat out, and the next beat is taken only after the result
// is loaded. A push_start writes its eight header bytes one per cycle through
// the single write port of the byte-wide ring memory. The first pop of a
// message reads its length through the registered read port before its first
// body byte; later pops of the message read only their body byte. Writing
// cfg_wdata empties the ring; the ring memory needs no clearing pass after reset.
module length_prefixed_message_ring (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [16:0] cfg_wdata,     // ring_size
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // msg_length[15:0], data_byte[23:16]
    input  logic [1:0]  s_axis_tuser,  // action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,  // out_byte[7:0], out_length[23:8],
                                       // message_count[36:24], zero[39:37]
    output logic [1:0]  m_axis_tuser,  // status
    output logic        m_axis_tlast   // last
);

    lpmr_pkg::lpmr_cmd_t  cmd;
    lpmr_pkg::lpmr_stat_t stat;
    logic [7:0]  out_byte;
    logic [15:0] out_length;
    logic [12:0] out_count;

    lpmr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    lpmr_dpath u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_action  (s_axis_tuser),
        .in_length  (s_axis_tdata[15:0]),
        .in_byte    (s_axis_tdata[23:16]),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_status (m_axis_tuser),
        .out_byte   (out_byte),
        .out_length (out_length),
        .out_last   (m_axis_tlast),
        .out_count  (out_count),
        .cmd        (cmd),
        .stat       (stat)
    );

    assign m_axis_tdata = {3'b000, out_count, out_length, out_byte};

endmodule

// File: hdl/lpmr_ctrl.sv
module lpmr_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  lpmr_pkg::lpmr_stat_t stat,
    output lpmr_pkg::lpmr_cmd_t  cmd
);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b00_0000_0001,
        S_DEC   = 10'b00_0000_0010,
        S_HWR   = 10'b00_0000_0100,
        S_HRD0  = 10'b00_0000_1000,
        S_HRD1  = 10'b00_0001_0000,
        S_HRD2  = 10'b00_0010_0000,
        S_BCHK  = 10'b00_0100_0000,
        S_BWAIT = 10'b00_1000_0000,
        S_PEND  = 10'b01_0000_0000,
        S_RESP  = 10'b10_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.status = lpmr_pkg::ST_OK;
        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    cmd.latch_in = 1'b1;
                    state_next   = S_DEC;
                end
            end
            S_DEC: begin
                unique case (stat.act)
                    lpmr_pkg::ACT_PUSH_START: begin
                        if (stat.push_open) begin
                            cmd.set_status = 1'b1;
                            cmd.status     = lpmr_pkg::ST_BAD;
                            state_next     = S_RESP;
                        end else if (stat.full) begin
                            cmd.set_status = 1'b1;
                            cmd.status     = lpmr_pkg::ST_FULL;
                            state_next     = S_RESP;
                        end else begin
                            state_next = S_HWR;
                        end
                    end
                    lpmr_pkg::ACT_PUSH_BYTE: begin
                        if (!stat.push_open) begin
                            cmd.set_status = 1'b1;
                            cmd.status     = lpmr_pkg::ST_BAD;
                        end else begin
                            cmd.wr_body = 1'b1;
                        end
                        state_next = S_RESP;
                    end
                    lpmr_pkg::ACT_POP_BYTE: begin
                        if (stat.empty) begin
                            cmd.set_status = 1'b1;
                            cmd.status     = lpmr_pkg::ST_EMPTY;
                            state_next     = S_RESP;
                        end else if (stat.pop_open) begin
                            state_next = S_BCHK;
                        end else begin
                            cmd.start_rd = 1'b1;
                            state_next   = S_HRD0;
                        end
                    end
                    default: begin
                        cmd.set_status = 1'b1;
                        cmd.status     = lpmr_pkg::ST_BAD;
                        state_next     = S_RESP;
                    end
                endcase
            end
            S_HWR: begin
                cmd.wr_hdr = 1'b1;
                if (stat.hdr_done) begin
                    state_next = S_RESP;
                end
            end
            S_HRD0: begin
                cmd.adv_cursor = 1'b1;
                state_next     = S_HRD1;
            end
            S_HRD1: begin
                cmd.cap_lo = 1'b1;
                state_next = S_HRD2;
            end
            S_HRD2: begin
                cmd.cap_hi = 1'b1;
                state_next = S_BCHK;
            end
            S_BCHK: begin
                cmd.body_step = 1'b1;
                state_next    = stat.pop_left_zero ? S_PEND : S_BWAIT;
            end
            S_BWAIT: begin
                cmd.cap_body = 1'b1;
                state_next   = stat.pop_left_zero ? S_PEND : S_RESP;
            end
            S_PEND: begin
                cmd.pop_end = 1'b1;
                state_next  = S_RESP;
            end
            S_RESP: begin
                if (stat.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: hdl/lpmr_dpath.sv
module lpmr_dpath (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [16:0]         cfg_wdata,
    input  logic [1:0]          in_action,
    input  logic [15:0]         in_length,
    input  logic [7:0]          in_byte,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [1:0]          out_status,
    output logic [7:0]          out_byte,
    output logic [15:0]         out_length,
    output logic                out_last,
    output logic [12:0]         out_count,
    input  lpmr_pkg::lpmr_cmd_t  cmd,
    output lpmr_pkg::lpmr_stat_t stat
);

    localparam int POS_W  = lpmr_pkg::POS_W;
    localparam int SIZE_W = lpmr_pkg::SIZE_W;
    localparam int LEN_W  = lpmr_pkg::LEN_W;
    localparam int CNT_W  = lpmr_pkg::CNT_W;
    localparam int HC_W   = lpmr_pkg::HDR_CNT_W;

    logic [7:0] mem [lpmr_pkg::RING_BYTES];
    logic [7:0] rd_data_reg;

    logic [SIZE_W-1:0]     size_reg;
    logic [POS_W-1:0]      reserve_reg, commit_reg, read_reg, cursor_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [LEN_W-1:0]      push_left_reg, pop_left_reg, pop_len_reg;
    logic                  pop_open_reg;
    lpmr_pkg::action_t     act_reg;
    logic [LEN_W-1:0]      len_reg;
    logic [7:0]            byte_reg;
    logic [HC_W-1:0]       hdr_cnt_reg;
    logic [7:0]            lo_reg;
    lpmr_pkg::status_t     st_reg;
    logic [7:0]            ob_reg;
    logic [LEN_W-1:0]      olen_reg;
    logic                  last_reg;

    logic                  out_valid_reg;
    logic [1:0]            out_status_reg;
    logic [7:0]            out_byte_reg;
    logic [LEN_W-1:0]      out_length_reg;
    logic                  out_last_reg;
    logic [CNT_W-1:0]      out_count_reg;

    logic                  mem_we;
    logic [7:0]            mem_wdata;
    logic [7:0]            hdr_byte;
    logic [SIZE_W-1:0]     used;
    logic [SIZE_W-1:0]     free_bytes;
    logic [SIZE_W:0]       need;
    logic [POS_W-1:0]      reserve_inc;
    logic [LEN_W-1:0]      push_left_dec;

    assign reserve_inc   = lpmr_pkg::wrap_inc(reserve_reg, size_reg);
    assign push_left_dec = push_left_reg - LEN_W'(1);

    always_comb begin
        if (reserve_reg >= read_reg) begin
            used = SIZE_W'(reserve_reg) - SIZE_W'(read_reg);
        end else begin
            used = SIZE_W'(reserve_reg) + size_reg - SIZE_W'(read_reg);
        end
        free_bytes = size_reg - SIZE_W'(1) - used;
        need       = (SIZE_W+1)'(len_reg) + (SIZE_W+1)'(lpmr_pkg::HEADER_BYTES);
    end

    always_comb begin
        unique case (hdr_cnt_reg)
            HC_W'(0): hdr_byte = len_reg[7:0];
            HC_W'(1): hdr_byte = len_reg[15:8];
            default:  hdr_byte = 8'd0;
        endcase
    end

    assign mem_we    = cmd.wr_hdr | cmd.wr_body;
    assign mem_wdata = cmd.wr_hdr ? hdr_byte : byte_reg;

    always_ff @(posedge clk) begin
        if (mem_we) begin
            mem[reserve_reg] <= mem_wdata;
        end
        rd_data_reg <= mem[cursor_reg];
    end

    always_comb begin
        stat.act           = act_reg;
        stat.push_open     = (push_left_reg != '0);
        stat.full          = (need > (SIZE_W+1)'(free_bytes));
        stat.empty         = !pop_open_reg && (read_reg == commit_reg);
        stat.pop_open      = pop_open_reg;
        stat.pop_left_zero = (pop_left_reg == '0);
        stat.hdr_done      = (hdr_cnt_reg == HC_W'(lpmr_pkg::HEADER_BYTES - 1));
        stat.out_free      = !out_valid_reg || out_ready;
    end

    // Ring control state; a configuration write empties the ring.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            size_reg      <= SIZE_W'(lpmr_pkg::SIZE_MAX);
            reserve_reg   <= '0;
            commit_reg    <= '0;
            read_reg      <= '0;
            cursor_reg    <= '0;
            count_reg     <= '0;
            push_left_reg <= '0;
            pop_left_reg  <= '0;
            pop_len_reg   <= '0;
            pop_open_reg  <= 1'b0;
            hdr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else if (cfg_we) begin
            size_reg      <= lpmr_pkg::clamp_size(cfg_wdata);
            reserve_reg   <= '0;
            commit_reg    <= '0;
            read_reg      <= '0;
            cursor_reg    <= '0;
            count_reg     <= '0;
            push_left_reg <= '0;
            pop_left_reg  <= '0;
            pop_len_reg   <= '0;
            pop_open_reg  <= 1'b0;
            hdr_cnt_reg   <= '0;
        end else begin
            if (cmd.latch_in) begin
                hdr_cnt_reg <= '0;
            end
            if (cmd.wr_hdr) begin
                reserve_reg <= reserve_inc;
                hdr_cnt_reg <= hdr_cnt_reg + HC_W'(1);
                if (stat.hdr_done) begin
                    push_left_reg <= len_reg;
                    if (len_reg == '0) begin
                        commit_reg <= reserve_inc;
                        count_reg  <= count_reg + CNT_W'(1);
                    end
                end
            end
            if (cmd.wr_body) begin
                reserve_reg   <= reserve_inc;
                push_left_reg <= push_left_dec;
                if (push_left_dec == '0) begin
                    commit_reg <= reserve_inc;
                    count_reg  <= count_reg + CNT_W'(1);
                end
            end
            if (cmd.start_rd) begin
                cursor_reg <= read_reg;
            end
            if (cmd.adv_cursor) begin
                cursor_reg <= lpmr_pkg::wrap_inc(cursor_reg, size_reg);
            end
            if (cmd.cap_hi) begin
                pop_len_reg  <= {rd_data_reg, lo_reg};
                pop_left_reg <= {rd_data_reg, lo_reg};
                pop_open_reg <= 1'b1;
                cursor_reg   <= lpmr_pkg::wrap_add_hdr(read_reg, size_reg);
            end
            if (cmd.body_step && (pop_left_reg != '0)) begin
                cursor_reg   <= lpmr_pkg::wrap_inc(cursor_reg, size_reg);
                pop_left_reg <= pop_left_reg - LEN_W'(1);
            end
            if (cmd.pop_end) begin
                read_reg     <= cursor_reg;
                count_reg    <= count_reg - CNT_W'(1);
                pop_open_reg <= 1'b0;
            end
            if (cmd.load_out) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Item and result payload registers.
    always_ff @(posedge clk) begin
        if (cmd.latch_in) begin
            act_reg  <= lpmr_pkg::action_t'(in_action);
            len_reg  <= in_length;
            byte_reg <= in_byte;
            st_reg   <= lpmr_pkg::ST_OK;
            ob_reg   <= '0;
            olen_reg <= '0;
            last_reg <= 1'b0;
        end
        if (cmd.set_status) begin
            st_reg <= cmd.status;
        end
        if (cmd.wr_hdr && stat.hdr_done && (len_reg == '0)) begin
            last_reg <= 1'b1;
        end
        if (cmd.wr_body && (push_left_dec == '0)) begin
            last_reg <= 1'b1;
        end
        if (cmd.cap_lo) begin
            lo_reg <= rd_data_reg;
        end
        if (cmd.body_step) begin
            olen_reg <= pop_len_reg;
        end
        if (cmd.cap_body) begin
            ob_reg <= rd_data_reg;
        end
        if (cmd.pop_end) begin
            last_reg <= 1'b1;
        end
        if (cmd.load_out) begin
            out_status_reg <= st_reg;
            out_byte_reg   <= ob_reg;
            out_length_reg <= olen_reg;
            out_last_reg   <= last_reg;
            out_count_reg  <= count_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_byte   = out_byte_reg;
    assign out_length = out_length_reg;
    assign out_last   = out_last_reg;
    assign out_count  = out_count_reg;

endmodule

// File: hdl/lpmr_checker.sv
module lpmr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    // A stalled result beat stays up and keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat dropped or changed while stalled");

    // Only a successful beat carries a popped byte or length.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser != lpmr_pkg::ST_OK) |-> m_axis_tdata[23:0] == 24'd0)
        else $error("byte or length reported on a failed beat");

    // Only a successful beat can end a message.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser == lpmr_pkg::ST_OK)
        else $error("last flag on a failed beat");

    // An empty answer means no committed message is left.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == lpmr_pkg::ST_EMPTY) |-> m_axis_tdata[36:24] == 13'd0)
        else $error("empty answer with messages stored");

endmodule

bind length_prefixed_message_ring lpmr_checker u_lpmr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
